// File: design/scaled_glyph_rectangle_emitter_assert.svh
// Assertion macros for the scaled glyph rectangle emitter.
// Included by the top level; needs nothing else.
`ifndef SCALED_GLYPH_RECTANGLE_EMITTER_ASSERT_SVH
`define SCALED_GLYPH_RECTANGLE_EMITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgre assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgre assertion failed");

`endif

// File: design/sgre_pkg.sv
// Shared types and constants of the scaled glyph rectangle emitter.
// Used by all modules of the block but sgre_ram; depends on nothing.
`timescale 1ns / 1ps

package sgre_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int ROW_W       = 3;
	localparam int COL_W       = 3;
	localparam int CODE_W      = 8;
	localparam int COORD_W     = 16;
	localparam int S_DATA_W    = 56;
	localparam int M_DATA_W    = 80;

	localparam logic [7:0]       TRANSPARENT = 8'd255;
	localparam logic [ROW_W-1:0] LAST_ROW    = 3'd7;
	localparam logic [COL_W-1:0] LAST_COL    = 3'd7;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAGE     = 3'd0,
		REG_SCALE_X  = 3'd1,
		REG_SCALE_Y  = 3'd2,
		REG_FG_COLOR = 3'd3,
		REG_BG_COLOR = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [7:0] page;
		logic [6:0] scale_x;
		logic [6:0] scale_y;
		logic [7:0] fg_color;
		logic [7:0] bg_color;
	} cfg_t;

	typedef struct packed {
		logic                      kind;
		logic [CODE_W-1:0]         char_code;
		logic [ROW_W-1:0]          row_index;
		logic [7:0]                row_bits;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
	} item_t;

	typedef struct packed {
		logic [7:0]                page;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] bottom;
		logic [7:0]                color;
	} rect_t;

	typedef struct packed {
		logic  valid;
		logic  fin;
		rect_t rect;
	} cand_t;

endpackage

// File: design/sgre_ram.sv
// Generic single-port RAM with a registered read.
// Stand-alone; used for the glyph memory.
`timescale 1ns / 1ps

module sgre_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// File: design/sgre_modred.sv
// Bit-serial reduction of a character code modulo the character count.
// Uses sgre_pkg; one code bit is taken per cycle.
`timescale 1ns / 1ps

module sgre_modred #(
	parameter int CHAR_COUNT = 256,
	localparam int CW = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sgre_pkg::CODE_W-1:0] code,
	output logic                      done,
	output logic [CW-1:0]             rem
);

	import sgre_pkg::*;

	localparam logic [CODE_W:0] DIVISOR = (CODE_W + 1)'(CHAR_COUNT);

	logic              busy_q;
	logic              done_q;
	logic [2:0]        count_q;
	logic [CODE_W-1:0] shift_q;
	logic [CODE_W:0]   rem_q;
	logic [CODE_W:0]   trial;

	assign trial = {rem_q[CODE_W-1:0], shift_q[CODE_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 3'd1;
				if (count_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= code;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[CODE_W-2:0], 1'b0};
			rem_q   <= (trial >= DIVISOR) ? (trial - DIVISOR) : trial;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[CW-1:0];

endmodule

// File: design/sgre_walker.sv
// Glyph walker: owns the glyph memory, reduces the code, and steps through
// the glyph one pixel per cycle unless stalled, producing rectangle
// candidates. Uses sgre_pkg, sgre_modred and sgre_ram.
`timescale 1ns / 1ps

module sgre_walker #(
	parameter int CHAR_COUNT = 256,
	localparam int CW = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sgre_pkg::cfg_t  cfg,
	input  logic            item_valid,
	output logic            item_ready,
	input  sgre_pkg::item_t item,
	output sgre_pkg::cand_t cand,
	input  logic            cand_ready
);

	import sgre_pkg::*;

	typedef enum logic [2:0] {
		W_IDLE,
		W_RED,
		W_FETCH,
		W_EMIT,
		W_END
	} wstate_t;

	wstate_t          state_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	item_t             item_q;
	logic [7:0]        mask_q;
	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] top_q;

	logic              accept;
	logic              red_done;
	logic [CW-1:0]     code_rem;
	logic              ram_we;
	logic              ram_re;
	logic [CW+ROW_W-1:0] ram_addr;
	logic [7:0]        ram_rdata;
	logic              transparent;
	logic              pix_set;
	logic              emit;
	logic              advance;
	logic [COORD_W-1:0] sx_m1;
	logic [COORD_W-1:0] sy_m1;
	logic [COORD_W-1:0] sx_ext;
	logic [COORD_W-1:0] sy_ext;

	assign item_ready = (state_q == W_IDLE);
	assign accept     = item_valid && item_ready;

	sgre_modred #(
		.CHAR_COUNT(CHAR_COUNT)
	) u_modred (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.code  (item.char_code),
		.done  (red_done),
		.rem   (code_rem)
	);

	assign ram_we = (state_q == W_RED) && red_done && (item_q.kind == KIND_LOAD);
	assign ram_re = ((state_q == W_RED) && red_done && (item_q.kind == KIND_DRAW))
		|| (advance && (col_q == LAST_COL) && (row_q != LAST_ROW));

	always_comb begin
		if (state_q == W_RED) begin
			ram_addr = {code_rem,
				(item_q.kind == KIND_LOAD) ? item_q.row_index : {ROW_W{1'b0}}};
		end else begin
			ram_addr = {code_rem, row_q + 3'd1};
		end
	end

	sgre_ram #(
		.WIDTH (8),
		.ADDR_W(CW + ROW_W)
	) u_glyph_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(item_q.row_bits),
		.rdata(ram_rdata)
	);

	assign sx_ext      = {{(COORD_W - 7){1'b0}}, cfg.scale_x};
	assign sy_ext      = {{(COORD_W - 7){1'b0}}, cfg.scale_y};
	assign sx_m1       = sx_ext - 16'd1;
	assign sy_m1       = sy_ext - 16'd1;
	assign transparent = (cfg.bg_color == TRANSPARENT);
	assign pix_set     = mask_q[7];
	assign emit        = !transparent || pix_set;
	assign advance     = (state_q == W_EMIT) && (!emit || cand_ready);

	always_comb begin
		cand.valid       = (state_q == W_EMIT) && emit;
		cand.fin         = (state_q == W_END);
		cand.rect.page   = cfg.page;
		cand.rect.left   = left_q;
		cand.rect.top    = top_q;
		cand.rect.right  = left_q + sx_m1;
		cand.rect.bottom = top_q + sy_m1;
		cand.rect.color  = pix_set ? cfg.fg_color : cfg.bg_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (accept) begin
						state_q <= W_RED;
					end
				end
				W_RED: begin
					if (red_done) begin
						row_q   <= '0;
						state_q <= (item_q.kind == KIND_LOAD) ? W_IDLE : W_FETCH;
					end
				end
				W_FETCH: begin
					col_q   <= '0;
					state_q <= W_EMIT;
				end
				W_EMIT: begin
					if (advance) begin
						col_q <= col_q + 3'd1;
						if (col_q == LAST_COL) begin
							if (row_q == LAST_ROW) begin
								state_q <= W_END;
							end else begin
								row_q   <= row_q + 3'd1;
								state_q <= W_FETCH;
							end
						end
					end
				end
				W_END: begin
					if (cand_ready) begin
						state_q <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			top_q  <= item.origin_y;
		end
		if (state_q == W_FETCH) begin
			mask_q <= ram_rdata;
			left_q <= item_q.origin_x;
		end else if (advance) begin
			mask_q <= {mask_q[6:0], 1'b0};
			left_q <= left_q + sx_ext;
			if (col_q == LAST_COL) begin
				top_q <= top_q + sy_ext;
			end
		end
	end

endmodule

// File: design/sgre_outbuf.sv
// Output stage: holds one candidate back so that the final rectangle of a
// character can be marked, and drives the master-side stream register.
// Uses sgre_pkg.
`timescale 1ns / 1ps

module sgre_outbuf (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sgre_pkg::cand_t                 cand,
	output logic                            cand_ready,
	output logic                            pend_valid,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sgre_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast
);

	import sgre_pkg::*;

	logic  pend_valid_q;
	logic  out_valid_q;
	logic  out_last_q;
	rect_t pend_q;
	rect_t out_q;
	logic  out_free;
	logic  take_pix;
	logic  take_fin;

	assign out_free   = !out_valid_q || m_tready;
	assign cand_ready = !pend_valid_q || out_free;
	assign take_pix   = cand.valid && cand_ready;
	assign take_fin   = cand.fin && cand_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((take_pix || take_fin) && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (take_pix) begin
				pend_valid_q <= 1'b1;
			end else if (take_fin) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((take_pix || take_fin) && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= take_fin;
		end
		if (take_pix) begin
			pend_q <= cand.rect;
		end
	end

	assign pend_valid = pend_valid_q;
	assign m_tvalid   = out_valid_q;
	assign m_tlast    = out_last_q;
	assign m_tdata    = {out_q.color, out_q.bottom, out_q.right, out_q.top, out_q.left,
		out_q.page};

endmodule

// File: design/scaled_glyph_rectangle_emitter.sv
// Scaled glyph rectangle emitter, top level: configuration registers,
// stream ports and the walker and output stage. Uses sgre_pkg, sgre_walker,
// sgre_outbuf and the assertion macro header.
//
// A load item writes one glyph row. A draw item first reduces the character
// code one bit a cycle, then per glyph row reads the glyph memory and steps
// through its pixels, one pixel per cycle when the output is not stalled.
// One rectangle per glyph pixel leaves on the master stream (none for clear
// pixels in transparent mode), and tlast marks the final rectangle of a
// character. The glyph memory has no reset: a row must be loaded before any
// character that uses it is drawn. Configuration writes are always accepted
// and must be made while the block is idle.
`timescale 1ns / 1ps
`include "scaled_glyph_rectangle_emitter_assert.svh"

module scaled_glyph_rectangle_emitter #(
	parameter int CHAR_COUNT = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// char_code, row_index, row_bits, origin_x, origin_y, zero fill
	input  logic [sgre_pkg::S_DATA_W-1:0]      s_tdata,
	// kind
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// rect_page, left, top, right, bottom, color
	output logic [sgre_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgre_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [7:0]                         cfg_data
);

	import sgre_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	cand_t cand;
	logic  cand_ready;
	logic  pend_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page     <= 8'd0;
			cfg_q.scale_x  <= 7'd1;
			cfg_q.scale_y  <= 7'd1;
			cfg_q.fg_color <= 8'd15;
			cfg_q.bg_color <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAGE:     cfg_q.page     <= cfg_data;
				REG_SCALE_X:  cfg_q.scale_x  <= cfg_data[6:0];
				REG_SCALE_Y:  cfg_q.scale_y  <= cfg_data[6:0];
				REG_FG_COLOR: cfg_q.fg_color <= cfg_data;
				REG_BG_COLOR: cfg_q.bg_color <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		item.kind      = s_tuser[0];
		item.char_code = s_tdata[7:0];
		item.row_index = s_tdata[10:8];
		item.row_bits  = s_tdata[18:11];
		item.origin_x  = s_tdata[34:19];
		item.origin_y  = s_tdata[50:35];
	end

	sgre_walker #(
		.CHAR_COUNT(CHAR_COUNT)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item      (item),
		.cand      (cand),
		.cand_ready(cand_ready)
	);

	sgre_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand),
		.cand_ready(cand_ready),
		.pend_valid(pend_valid),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// An accepted item keeps the walker busy for at least the next cycle.
	`SGRE_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// An idle walker never leaves a rectangle held back in the output stage.
	`SGRE_ASSERT_IMPL(a_idle_no_pending, clk, arst_n, s_tready, !pend_valid)
	// A stalled candidate is held until the output stage takes it.
	`SGRE_ASSERT_NEXT(a_cand_holds, clk, arst_n, cand.valid && !cand_ready, cand.valid && $stable(cand.rect))

endmodule

// File: tb/glyph_rect_checker.sv
// Checker for the scaled glyph rectangle emitter: keeps its own glyph store and
// register copy, predicts the rectangles of every draw and compares each output transfer.
// Depends on sgre_pkg for the register indexes, item kinds and bus widths.
`timescale 1ns / 1ps

module glyph_rect_checker
	import sgre_pkg::*;
#(
	parameter int CHAR_COUNT = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [S_DATA_W-1:0]    s_tdata,
	input  logic [0:0]             s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [M_DATA_W-1:0]    m_tdata,
	input  logic                   m_tlast,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	output int                     error_count,
	output int                     pending_count,
	output int                     rect_count
);

	typedef struct packed {
		logic [7:0]  page;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] right;
		logic [15:0] bottom;
		logic [7:0]  color;
		logic        last;
	} screen_rect_t;

	screen_rect_t expected_rects[$];
	logic [7:0]   glyph_rows [0:CHAR_COUNT*8-1];
	logic [7:0]   page_reg;
	logic [6:0]   scale_x_reg;
	logic [6:0]   scale_y_reg;
	logic [7:0]   fg_reg;
	logic [7:0]   bg_reg;
	int           mismatches = 0;
	int           checked = 0;

	task automatic expand_glyph(input logic [7:0] code, input logic [15:0] ox,
			input logic [15:0] oy);
		screen_rect_t held;
		screen_rect_t fresh;
		bit           have_held;
		logic [7:0]   pattern;
		logic [15:0]  row_top;
		have_held = 1'b0;
		held      = '0;
		for (int row = 0; row < 8; row++) begin
			pattern = glyph_rows[(int'(code) % CHAR_COUNT) * 8 + row];
			row_top = oy + 16'(row * scale_y_reg);
			for (int col = 0; col < 8; col++) begin
				if (bg_reg == TRANSPARENT && !pattern[7-col])
					continue;
				fresh.page   = page_reg;
				fresh.left   = ox + 16'(col * scale_x_reg);
				fresh.right  = fresh.left + 16'(scale_x_reg) - 16'd1;
				fresh.top    = row_top;
				fresh.bottom = row_top + 16'(scale_y_reg) - 16'd1;
				fresh.color  = pattern[7-col] ? fg_reg : bg_reg;
				fresh.last   = 1'b0;
				if (have_held)
					expected_rects.push_back(held);
				held      = fresh;
				have_held = 1'b1;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			expected_rects.push_back(held);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] seen);
		if (seen !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(seen));
			mismatches++;
		end
	endtask

	task automatic compare_rect(input screen_rect_t seen);
		screen_rect_t want;
		if (expected_rects.size() == 0) begin
			$error("Rectangle transfer with nothing expected: left %0d top %0d",
				$signed(seen.left), $signed(seen.top));
			mismatches++;
			return;
		end
		want = expected_rects.pop_front();
		checked++;
		check_field("rect_page", want.page, seen.page);
		check_field("left", want.left, seen.left);
		check_field("top", want.top, seen.top);
		check_field("right", want.right, seen.right);
		check_field("bottom", want.bottom, seen.bottom);
		check_field("color", want.color, seen.color);
		check_field("last", want.last, seen.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_reg    = 8'd0;
			scale_x_reg = 7'd1;
			scale_y_reg = 7'd1;
			fg_reg      = 8'd15;
			bg_reg      = 8'd255;
			expected_rects.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_PAGE:     page_reg    = cfg_data;
					REG_SCALE_X:  scale_x_reg = cfg_data[6:0];
					REG_SCALE_Y:  scale_y_reg = cfg_data[6:0];
					REG_FG_COLOR: fg_reg      = cfg_data;
					REG_BG_COLOR: bg_reg      = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				compare_rect({m_tdata[7:0], m_tdata[23:8], m_tdata[39:24], m_tdata[55:40],
					m_tdata[71:56], m_tdata[79:72], m_tlast});
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == KIND_LOAD)
					glyph_rows[(int'(s_tdata[7:0]) % CHAR_COUNT) * 8 + int'(s_tdata[10:8])] =
						s_tdata[18:11];
				else
					expand_glyph(s_tdata[7:0], s_tdata[34:19], s_tdata[50:35]);
			end
		end
		error_count   <= mismatches;
		pending_count <= expected_rects.size();
		rect_count    <= checked;
	end

endmodule

// File: tb/testbench.sv
// Top of the glyph rectangle emitter bench: clock, reset, glyph loads, draws and
// register settings under varying back-pressure. Needs sgre_pkg, the emitter and
// glyph_rect_checker, which judges every rectangle; this module gives the verdict.
`timescale 1ns / 1ps

module testbench;
	import sgre_pkg::*;

	localparam int CHAR_COUNT    = 256;
	localparam int ITEM_TARGET   = 250;
	localparam int DIRECTED      = 20;
	localparam int SEGMENTS      = 6;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 1000000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data  = '0;

	int         error_count;
	int         pending_count;
	int         rect_count;
	int         sender_idle_pct    = 31;
	int         receiver_stall_pct = 47;
	int         items_sent         = 0;
	int         draws_sent         = 0;
	int         settings_used      = 0;
	int         cycle_count        = 0;
	logic [7:0] loaded_rows [0:CHAR_COUNT-1];
	logic [7:0] ready_codes[$];

	scaled_glyph_rectangle_emitter #(
		.CHAR_COUNT(CHAR_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	glyph_rect_checker #(
		.CHAR_COUNT(CHAR_COUNT)
	) rect_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.error_count(error_count),
		.pending_count(pending_count),
		.rect_count(rect_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d rectangles outstanding",
				cycle_count, pending_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [7:0] random_pattern();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] random_coord();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF - 16'($urandom_range(0, 600));
			1: return 16'h8000 + 16'($urandom_range(0, 600));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] code, input logic [2:0] row,
			input logic [7:0] bits, input logic [15:0] ox, input logic [15:0] oy);
		bit was_ready;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'd0, oy, ox, bits, row, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (kind == KIND_DRAW) begin
			draws_sent++;
		end else begin
			was_ready = (loaded_rows[code] == 8'hFF);
			loaded_rows[code][row] = 1'b1;
			if (!was_ready && loaded_rows[code] == 8'hFF)
				ready_codes.push_back(code);
		end
	endtask

	task automatic draw_char(input logic [7:0] code, input logic [15:0] ox,
			input logic [15:0] oy);
		send_item(KIND_DRAW, code, 3'($urandom_range(0, 7)), random_pattern(), ox, oy);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_config(input logic [7:0] page, input logic [6:0] sx,
			input logic [6:0] sy, input logic [7:0] fg, input logic [7:0] bg);
		write_reg(REG_PAGE, page);
		write_reg(REG_SCALE_X, {1'b0, sx});
		write_reg(REG_SCALE_Y, {1'b0, sy});
		write_reg(REG_FG_COLOR, fg);
		write_reg(REG_BG_COLOR, bg);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_item();
		int         pick;
		logic [7:0] code;
		pick = $urandom_range(0, 99);
		if (ready_codes.size() == 0 || pick < 10) begin
			code = 8'($urandom_range(0, 255));
			for (int row = 0; row < 8; row++)
				send_item(KIND_LOAD, code, 3'(row), random_pattern(), random_coord(),
					random_coord());
		end else if (pick < 25) begin
			send_item(KIND_LOAD, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
				random_pattern(), random_coord(), random_coord());
		end else begin
			code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
			draw_char(code, random_coord(), random_coord());
		end
	endtask

	initial begin
		logic [7:0] directed_rows [0:7];
		for (int c = 0; c < CHAR_COUNT; c++)
			loaded_rows[c] = 8'h00;
		directed_rows = '{8'hFF, 8'h00, 8'h81, 8'h7E, 8'h80, 8'h01, 8'hAA, 8'h55};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register values after reset: transparent mode with unit scale.
		for (int row = 0; row < 8; row++)
			send_item(KIND_LOAD, 8'd0, 3'(row), directed_rows[row], 16'd0, 16'd0);
		for (int row = 0; row < 8; row++)
			send_item(KIND_LOAD, 8'd255, 3'(row), 8'h00, 16'hFFFF, 16'hFFFF);
		draw_char(8'd0, 16'd0, 16'd0);
		draw_char(8'd0, 16'h7FFF, 16'h7FFF);
		draw_char(8'd255, 16'h8000, 16'h8000);
		draw_char(8'd0, 16'hFFFF, 16'hFFFF);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			case (seg / 2)
				0: begin
					sender_idle_pct    = 31;
					receiver_stall_pct = 47;
				end
				1: begin
					sender_idle_pct    = 47;
					receiver_stall_pct = 31;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			case (seg)
				0: program_config(8'hFF, 7'd127, 7'd127, 8'h00, 8'h00);
				1: program_config(8'h5A, 7'd0, 7'd0, 8'hFF, 8'hFE);
				2: program_config(8'($urandom_range(0, 255)), 7'($urandom_range(1, 127)),
					7'($urandom_range(1, 127)), 8'($urandom_range(0, 255)), TRANSPARENT);
				3: program_config(8'h00, 7'd1, 7'd1, 8'd15, TRANSPARENT);
				4: program_config(8'($urandom_range(0, 255)), 7'($urandom_range(1, 127)),
					7'($urandom_range(1, 127)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: program_config(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), TRANSPARENT);
			endcase
			if (seg == 1)
				draw_char(8'd255, 16'h8000, 16'h7FFF);
			while (items_sent < DIRECTED + (ITEM_TARGET - DIRECTED) * (seg + 1) / SEGMENTS)
				random_item();
		end

		wait_idle();
		$display("Covered %0d input transfers, %0d of them draws, over %0d register settings.",
			items_sent, draws_sent, settings_used + 1);
		$display("Checked %0d rectangle transfers field by field.", rect_count);
		if (error_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/sgre_pkg.sv
design/sgre_ram.sv
design/sgre_modred.sv
design/sgre_walker.sv
design/sgre_outbuf.sv
design/scaled_glyph_rectangle_emitter.sv
tb/glyph_rect_checker.sv
tb/testbench.sv
